FILE: src/sliding_window_median_top_macros.svh
// ----------------------------------------------------------------------------
// sliding window median assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define SWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window median check failed");

// next-cycle implication, quiet while in reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window median check failed");

// next-cycle implication that also watches reset itself
`define SWM_ASSERT_NEXT_RAW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sliding window median reset check failed");

`endif

FILE: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// shared widths, defaults and cell link types of the sliding window median
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W           = 32;
  localparam int MEDIAN_W           = 33;
  localparam int CFG_W              = 7;
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // flags one cell shows its neighbors
  typedef struct packed {
    logic le;    // holds a kept sample not above the incoming one
    logic gone;  // at or right of the removed slot
  } link_flags_t;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic take;  // sample transfer this cycle
    logic full;  // window full, oldest sample leaves
  } step_ctl_t;

endpackage

FILE: src/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top
// running median filter over a window of signed 32-bit samples
// ----------------------------------------------------------------------------
// Takes one sample transfer per clock cycle as long as results are taken,
// and gives twice the median of the last window_size samples (the sum of
// the two middle samples for an even window) once the window is full. The
// window lives in a chain of WINDOW_MAX cells kept in ascending order; in
// the cycle of a transfer every cell at once drops the oldest sample and
// makes room for the new one, so the chain keeps pace with the transfers.
// A result passes from the chain through a select stage, which picks the
// middle cells, and an add stage, which sums them; a stalled output holds
// up sample transfers only once both stages behind the chain are full.
// Writing window_size empties the window, as does the restart flag of a
// sample; sizes of zero act as one, sizes above WINDOW_MAX act as
// WINDOW_MAX. The window is tracked by a fill count, so there is no
// clearing pass after reset and the config port is always ready.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 restart,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::MEDIAN_W-1:0]  median_doubled,
  // config channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]            window_size
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // config and fill state
  logic [swm_pkg::CFG_W-1:0] window_len;
  logic [CNT_W-1:0]          fill;

  // result pipeline
  logic                                p_cell;   // result due from chain contents
  logic                                v_sel;
  logic signed [swm_pkg::SAMPLE_W-1:0] lo_val;
  logic signed [swm_pkg::SAMPLE_W-1:0] hi_val;

  logic [CNT_W-1:0]   win_n;
  logic [CNT_W-1:0]   fill_eff;
  logic [CNT_W-1:0]   fill_step;
  logic [AGE_W-1:0]   oldest_age;
  logic [AGE_W-1:0]   lo_idx;
  logic [AGE_W-1:0]   hi_idx;
  logic               take;
  logic               produce;
  logic               adv_out;
  logic               adv_sel;
  swm_pkg::step_ctl_t ctl;

  logic signed [swm_pkg::SAMPLE_W-1:0] cell_value [WINDOW_MAX];
  logic [AGE_W-1:0]                    cell_age   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]               le_vec;
  logic [WINDOW_MAX-1:0]               del_vec;
  logic [WINDOW_MAX-1:0]               gone_vec;

  // effective window length: zero acts as one, saturate at the chain length
  always_comb begin
    if (window_len == '0) begin
      win_n = CNT_W'(1);
    end else if (32'(window_len) > WINDOW_MAX) begin
      win_n = CNT_W'(WINDOW_MAX);
    end else begin
      win_n = CNT_W'(window_len);
    end
  end

  // handshake: the chain frees up as soon as the select stage can take its result
  assign adv_out   = !out_valid || out_ready;
  assign adv_sel   = !v_sel || adv_out;
  assign in_ready  = !p_cell || adv_sel;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // restart empties the window ahead of this sample
  assign fill_eff   = restart ? '0 : fill;
  assign ctl.take   = take;
  assign ctl.full   = (fill_eff >= win_n);
  assign fill_step  = ctl.full ? fill_eff : fill_eff + CNT_W'(1);
  assign produce    = (fill_step == win_n);
  assign oldest_age = AGE_W'(win_n - CNT_W'(1));

  // one-hot removal slot turned into a mask of that slot and all right of it
  assign gone_vec = ~(del_vec - WINDOW_MAX'(1));

  // middle cells: equal for an odd window, adjacent for an even one
  assign lo_idx = AGE_W'((win_n - CNT_W'(1)) >> 1);
  assign hi_idx = AGE_W'(win_n >> 1);

  // sorted cell chain
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [swm_pkg::SAMPLE_W-1:0] l_value;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_value;
    logic [AGE_W-1:0]                    l_age;
    logic [AGE_W-1:0]                    r_age;
    swm_pkg::link_flags_t                l_flags;
    swm_pkg::link_flags_t                r_flags;
    logic                                slot_valid;

    assign slot_valid = (CNT_W'(j) < fill_eff);

    // left end acts as a kept sample below anything, so a new minimum lands here
    if (j == 0) begin : g_left_end
      assign l_value = '0;
      assign l_age   = '0;
      assign l_flags = '{le: 1'b1, gone: 1'b0};
    end else begin : g_left
      assign l_value = cell_value[j-1];
      assign l_age   = cell_age[j-1];
      assign l_flags = '{le: le_vec[j-1], gone: gone_vec[j-1]};
    end

    // right end shifts in nothing kept
    if (j == WINDOW_MAX - 1) begin : g_right_end
      assign r_value = '0;
      assign r_age   = '0;
      assign r_flags = '{le: 1'b0, gone: 1'b0};
    end else begin : g_right
      assign r_value = cell_value[j+1];
      assign r_age   = cell_age[j+1];
      assign r_flags = '{le: le_vec[j+1], gone: gone_vec[j+1]};
    end

    swm_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (slot_valid),
      .gone        (gone_vec[j]),
      .oldest_age  (oldest_age),
      .sample      (sample),
      .left_value  (l_value),
      .left_age    (l_age),
      .left_flags  (l_flags),
      .right_value (r_value),
      .right_age   (r_age),
      .right_flags (r_flags),
      .value       (cell_value[j]),
      .age         (cell_age[j]),
      .le          (le_vec[j]),
      .del         (del_vec[j])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swm_pkg::WINDOW_RESET;
      fill       <= '0;
      p_cell     <= 1'b0;
      v_sel      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_len <= window_size;
        fill       <= '0;
      end else if (take) begin
        fill <= fill_step;
      end
      if (take) begin
        p_cell <= produce;
      end else if (adv_sel) begin
        p_cell <= 1'b0;
      end
      if (adv_sel) begin
        v_sel <= p_cell;
      end
      if (adv_out) begin
        out_valid <= v_sel;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv_sel) begin
      lo_val <= cell_value[lo_idx];
      hi_val <= cell_value[hi_idx];
    end
    if (adv_out) begin
      median_doubled <= $signed({lo_val[swm_pkg::SAMPLE_W-1], lo_val})
                      + $signed({hi_val[swm_pkg::SAMPLE_W-1], hi_val});
    end
  end

endmodule

FILE: src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted chain: holds a sample and its age, shifts with
// its neighbors on removal of the oldest sample and insertion of the new one
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                                clk,
  input  swm_pkg::step_ctl_t                  ctl,
  input  logic                                valid,
  input  logic                                gone,
  input  logic [AGE_W-1:0]                    oldest_age,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] left_value,
  input  logic [AGE_W-1:0]                    left_age,
  input  swm_pkg::link_flags_t                left_flags,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] right_value,
  input  logic [AGE_W-1:0]                    right_age,
  input  swm_pkg::link_flags_t                right_flags,
  output logic signed [swm_pkg::SAMPLE_W-1:0] value,
  output logic [AGE_W-1:0]                    age,
  output logic                                le,
  output logic                                del
);

  logic signed [swm_pkg::SAMPLE_W-1:0] own_value_c;
  logic signed [swm_pkg::SAMPLE_W-1:0] lft_value_c;
  logic signed [swm_pkg::SAMPLE_W-1:0] value_next;
  logic [AGE_W-1:0]                    own_age_c;
  logic [AGE_W-1:0]                    lft_age_c;
  logic [AGE_W-1:0]                    age_next;
  logic                                own_le_c;
  logic                                lft_le_c;

  assign del = ctl.full && valid && (age == oldest_age);
  assign le  = valid && !del && (value <= sample);

  // view of this slot and the left slot once the oldest sample is gone
  always_comb begin
    own_value_c = gone ? right_value     : value;
    own_age_c   = gone ? right_age       : age;
    own_le_c    = gone ? right_flags.le  : le;
    lft_value_c = left_flags.gone ? value : left_value;
    lft_age_c   = left_flags.gone ? age   : left_age;
    lft_le_c    = left_flags.gone ? le    : left_flags.le;
    if (own_le_c) begin
      value_next = own_value_c;
      age_next   = own_age_c + AGE_W'(1);
    end else if (lft_le_c) begin
      value_next = sample;
      age_next   = '0;
    end else begin
      value_next = lft_value_c;
      age_next   = lft_age_c + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

FILE: src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// port-level checks of the sliding window median, bound to the top level
// ----------------------------------------------------------------------------
`include "sliding_window_median_top_macros.svh"

module swm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // a stalled result holds
  `SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median_doubled))

  // samples are held off only behind a stalled result
  `SWM_ASSERT_SAME(a_in_stall, in_valid && !in_ready, out_valid && !out_ready)

  // config writes never wait
  `SWM_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

  // reset leaves no result and an open sample port
  `SWM_ASSERT_NEXT_RAW(a_reset, rst, !out_valid && in_ready)

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .median_doubled (median_doubled),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for sliding_window_median_top
// ----------------------------------------------------------------------------
// A short table of samples runs first at the reset window size. Its rows
// carry a hand-worked median, no median, or a request to use the predictor.
// Random phases follow at several window sizes, including zero, one and the
// saturating sizes. Both sides idle in random bursts. The output side holds
// off once for a long stretch, so the block backs up and stalls its input.
// Every result is compared against a queue of expected medians.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WMAX          = swm_pkg::WINDOW_MAX_DEFAULT;
  localparam int SETTLE_CYCLES = 6;    // drain margin for samples still inside the block
  localparam int LONG_HOLD     = 200;  // output stall long enough to back up the chain

  localparam logic signed [swm_pkg::SAMPLE_W-1:0] SMAX      = 32'sh7FFF_FFFF;
  localparam logic signed [swm_pkg::SAMPLE_W-1:0] SMIN      = 32'sh8000_0000;
  localparam logic signed [swm_pkg::MEDIAN_W-1:0] TWICE_MAX = 33'sh0_FFFF_FFFE;
  localparam logic signed [swm_pkg::MEDIAN_W-1:0] TWICE_MIN = 33'sh1_0000_0000;

  // how a stimulus row is checked
  typedef enum logic [1:0] {BY_MODEL, NO_MEDIAN, MEDIAN_IS} verdict_e;

  typedef struct packed {
    logic signed [swm_pkg::SAMPLE_W-1:0] smp;
    logic                                wipe;
    verdict_e                            how;
    logic signed [swm_pkg::MEDIAN_W-1:0] val;
  } probe_t;

  // dut ports, every input known from time zero
  logic                                clk;
  logic                                rst         = 1'b1;
  logic                                in_valid    = 1'b0;
  logic                                in_ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample      = '0;
  logic                                restart     = 1'b0;
  logic                                out_valid;
  logic                                out_ready   = 1'b1;
  logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled;
  logic                                cfg_valid   = 1'b0;
  logic                                cfg_ready;
  logic [swm_pkg::CFG_W-1:0]           window_size = swm_pkg::WINDOW_RESET;

  // shadow of the offered row, registered alongside the payload
  probe_t in_tag = '0;

  // predictor state
  logic [swm_pkg::CFG_W-1:0]           win_setting;
  logic signed [swm_pkg::SAMPLE_W-1:0] arrivals [WMAX];
  logic signed [swm_pkg::SAMPLE_W-1:0] ranked [$];
  int unsigned                         oldest_slot;

  logic signed [swm_pkg::MEDIAN_W-1:0] medians_due [$];

  // run control and bookkeeping
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int faults   = 0;
  int samples_in, medians_checked, wipes, settings_used, holds_done;

  probe_t script [$];

  sliding_window_median_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .median_doubled (median_doubled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // slide the predicted window by one sample; returns 1 when a median is due
  function automatic bit slide_window(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                                      input logic wipe,
                                      output logic signed [swm_pkg::MEDIAN_W-1:0] twice_med);
    int unsigned n, slot, k, lo, hi;
    n = (win_setting == 0) ? 1 : ((win_setting > WMAX) ? WMAX : win_setting);
    twice_med = '0;
    if (wipe) begin
      ranked.delete();
      oldest_slot = 0;
    end
    if (ranked.size() >= n) begin
      // full window: drop exactly one copy of the oldest sample
      slot = oldest_slot % n;
      k = 0;
      while (k < ranked.size() && ranked[k] != arrivals[slot]) k++;
      ranked.delete(k);
      arrivals[slot] = s;
      oldest_slot = (slot + 1) % n;
    end else begin
      arrivals[ranked.size()] = s;
    end
    // equal values go after the ones already held
    k = 0;
    while (k < ranked.size() && ranked[k] <= s) k++;
    ranked.insert(k, s);
    if (ranked.size() != n) return 1'b0;
    hi = n / 2;
    lo = (n % 2 == 1) ? hi : hi - 1;
    twice_med = {ranked[lo][swm_pkg::SAMPLE_W-1], ranked[lo]}
              + {ranked[hi][swm_pkg::SAMPLE_W-1], ranked[hi]};
    return 1'b1;
  endfunction

  function automatic probe_t row(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                                 input logic wipe, input verdict_e how,
                                 input logic signed [swm_pkg::MEDIAN_W-1:0] v);
    probe_t p;
    p.smp  = s;
    p.wipe = wipe;
    p.how  = how;
    p.val  = v;
    return p;
  endfunction

  // small values often so duplicates are common, some extremes, rest anything
  function automatic probe_t random_probe(input int unsigned wipe_odds);
    probe_t p;
    p = row('0, 1'b0, BY_MODEL, '0);
    p.wipe = (wipe_odds != 0) && ($urandom_range(0, wipe_odds - 1) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2: p.smp = $urandom_range(0, 8) - 32'd4;
      3: begin
        case ($urandom_range(0, 3))
          0: p.smp = SMIN;
          1: p.smp = SMAX;
          2: p.smp = '0;
          default: p.smp = -32'sd1;
        endcase
      end
      4: p.smp = SMIN + $urandom_range(0, 3);
      5: p.smp = SMAX - $urandom_range(0, 3);
      default: p.smp = $urandom;
    endcase
    return p;
  endfunction

  // offer one sample; returns at the edge of its transfer
  task automatic offer(input probe_t p);
    in_valid <= 1'b1;
    sample   <= p.smp;
    restart  <= p.wipe;
    in_tag   <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // random sender gap after a transfer
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected median has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (medians_due.size() != 0);
    // samples that give no median may still be inside the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [swm_pkg::CFG_W-1:0] size, input int count,
                           input int unsigned wipe_odds, input bit last,
                           input bit squeeze = 1'b0);
    drain();
    cfg_valid   <= 1'b1;
    window_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
    calm = last || ($urandom_range(0, 3) == 0);
    // long output hold-off while this phase keeps offering samples
    if (squeeze) hold_req = 1'b1;
    repeat (count) begin
      offer(random_probe(wipe_odds));
      maybe_pause();
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // predictor and checker, on the pre-edge values of every transfer
  always @(posedge clk) begin : scoreboard
    logic signed [swm_pkg::MEDIAN_W-1:0] model_med;
    logic signed [swm_pkg::MEDIAN_W-1:0] want;
    bit                                  due;
    if (rst) begin
      win_setting = swm_pkg::WINDOW_RESET;
      ranked.delete();
      oldest_slot = 0;
    end else begin
      // results first, so a median never meets its own sample's expectation
      if (out_valid && out_ready) begin
        if (medians_due.size() == 0) begin
          $error("median_doubled: unexpected result %0d, none pending", median_doubled);
          faults++;
        end else begin
          want = medians_due.pop_front();
          medians_checked++;
          if (median_doubled !== want) begin
            $error("median_doubled: expected %0d, got %0d", want, median_doubled);
            faults++;
          end
        end
      end
      // a size write empties the window
      if (cfg_valid && cfg_ready) begin
        win_setting = window_size;
        ranked.delete();
        oldest_slot = 0;
      end
      if (in_valid && in_ready) begin
        due = slide_window(sample, restart, model_med);
        samples_in++;
        if (restart) wipes++;
        case (in_tag.how)
          BY_MODEL:  if (due) medians_due.push_back(model_med);
          MEDIAN_IS: medians_due.push_back(in_tag.val);
          default:   ;
        endcase
      end
    end
  end

  initial begin : stimulus
    // directed rows at the reset window of three
    script.push_back(row(SMAX, 1'b0, NO_MEDIAN, '0));  // filling, no result
    script.push_back(row(SMAX, 1'b0, NO_MEDIAN, '0));
    script.push_back(row(SMAX, 1'b0, MEDIAN_IS, TWICE_MAX));
    script.push_back(row(SMIN, 1'b0, MEDIAN_IS, TWICE_MAX));
    script.push_back(row(SMIN, 1'b0, MEDIAN_IS, TWICE_MIN));
    script.push_back(row(SMIN, 1'b0, MEDIAN_IS, TWICE_MIN));
    script.push_back(row(32'sd0, 1'b1, NO_MEDIAN, '0));  // restart on a full window
    script.push_back(row(-32'sd1, 1'b0, NO_MEDIAN, '0));
    script.push_back(row(32'sd1, 1'b0, MEDIAN_IS, 33'sd0));
    script.push_back(row(32'sd1, 1'b0, MEDIAN_IS, 33'sd2));  // oldest zero leaves
    script.push_back(row(32'sd1, 1'b0, MEDIAN_IS, 33'sd2));  // all three equal
    script.push_back(row(32'sd1, 1'b0, MEDIAN_IS, 33'sd2));  // evict one duplicate
    script.push_back(row(32'sd5, 1'b1, NO_MEDIAN, '0));
    script.push_back(row(32'sd5, 1'b1, NO_MEDIAN, '0));    // back-to-back restarts
    script.push_back(row(32'sd5, 1'b0, NO_MEDIAN, '0));
    script.push_back(row(32'sd5, 1'b0, MEDIAN_IS, 33'sd10));
    script.push_back(row(-32'sd3, 1'b0, BY_MODEL, '0));
    script.push_back(row(32'sd100, 1'b0, BY_MODEL, '0));
    script.push_back(row(-32'sd100, 1'b0, BY_MODEL, '0));
    script.push_back(row(32'sd7, 1'b1, BY_MODEL, '0));
    script.push_back(row(32'sd12345678, 1'b0, BY_MODEL, '0));
    script.push_back(row(-32'sd87654321, 1'b0, BY_MODEL, '0));
    script.push_back(row(SMAX, 1'b0, BY_MODEL, '0));
    script.push_back(row(SMIN, 1'b0, BY_MODEL, '0));
    script.push_back(row(32'sd0, 1'b0, BY_MODEL, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      offer(script[i]);
      maybe_pause();
    end

    // zero acts as one: a median per sample, so the long hold backs the block up
    run_phase(7'd0, 40, 20, 1'b0, 1'b1);
    run_phase(7'd2, 40, 15, 1'b0);
    // above the maximum saturates, then the maximum itself
    run_phase(7'd127, 100, 0, 1'b0);
    run_phase(7'd64, 90, 400, 1'b0);
    run_phase(7'd1, 20, 10, 1'b0);
    run_phase(7'($urandom_range(0, 127)), 40, 30, 1'b0);
    run_phase(7'd5, 30, 12, 1'b0);
    // closing stretch without any idling
    run_phase(7'd4, 50, 15, 1'b1);

    drain();
    if (medians_due.size() != 0) begin
      $error("median_doubled: %0d expected results never arrived", medians_due.size());
      faults++;
    end

    $display("covered %0d samples (%0d with restart) over %0d window writes",
             samples_in, wipes, settings_used);
    $display("checked %0d medians, %0d long output hold-offs", medians_checked, holds_done);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
